[rtl/jec_pkg.sv]
// ----------------------------------------------------------------------------
// jec_pkg - joystick event conditioner shared definitions
// Sizes, event and register codes, controller states and the command and
// status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package jec_pkg;

    localparam int MAX_BUTTONS = 32;
    localparam int MAX_AXES    = 8;
    localparam int BTN_IDX_W   = $clog2(MAX_BUTTONS);
    localparam int AX_IDX_W    = $clog2(MAX_AXES);
    localparam int BTN_CNT_W   = 6;
    localparam int AX_CNT_W    = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [23:0] PUBLISH_TICKS_RST = 24'd1000;
    localparam logic [15:0] ACCUM_TICKS_RST   = 16'd1;
    localparam logic [14:0] DEADZONE_RST      = 15'd1638;
    localparam logic [19:0] AXIS_GAIN_RST     = 20'd68986;

    typedef enum logic [1:0] {
        FUNC_BUTTON  = 2'd0,
        FUNC_AXIS    = 2'd1,
        FUNC_TICK    = 2'd2,
        FUNC_UNKNOWN = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STICKY   = 3'd0,
        REG_DEADZONE = 3'd1,
        REG_GAIN     = 3'd2,
        REG_PUBLISH  = 3'd3,
        REG_ACCUM    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WR,
        ST_PUB
    } t_state;

    typedef struct packed {
        logic                accept;
        logic                pub_start;
        logic                mul;
        logic                store_wr;
        logic                load_out;
        logic [AX_IDX_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic                item_axis;
        logic                item_pub;
        logic [AX_IDX_W-1:0] last_k;
    } t_status;

endpackage

[rtl/jec_ifs.sv]
// ----------------------------------------------------------------------------
// jec_ifs - joystick event conditioner channel interfaces
// Event input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface jec_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        init_flag;
    logic [7:0]  number;
    logic signed [15:0] value;

    modport source(output valid, func, init_flag, number, value, input ready);
    modport sink(input valid, func, init_flag, number, value, output ready);
endinterface

interface jec_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] buttons;
    logic [5:0]  button_count;
    logic [3:0]  axis_count;
    logic        axis_valid;
    logic [2:0]  axis_index;
    logic signed [15:0] axis_value;
    logic        last;

    modport source(output valid, buttons, button_count, axis_count, axis_valid,
                   axis_index, axis_value, last, input ready);
    modport sink(input valid, buttons, button_count, axis_count, axis_valid,
                 axis_index, axis_value, last, output ready);
endinterface

interface jec_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/jec_ctrl.sv]
// ----------------------------------------------------------------------------
// jec_ctrl - joystick event conditioner controller
// Sequences event intake, the axis conditioning steps and the result
// stream of a publish; owns the result valid flag.
// ----------------------------------------------------------------------------
module jec_ctrl
    import jec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_st,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state              r_state, n_state;
    logic [AX_IDX_W-1:0] r_k, n_k;
    logic                r_out_valid, n_out_valid;
    logic                w_out_free;
    logic                w_pub_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pub_last = (r_k == i_st.last_k);

    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.k        = r_k;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.item_axis) begin
                        n_state = ST_MUL;
                    end else if (i_st.item_pub) begin
                        o_cmd.pub_start = 1'b1;
                        n_k             = '0;
                        n_state         = ST_PUB;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_WR;
            end
            ST_WR: begin
                o_cmd.store_wr = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_PUB: begin
                // advance one result per free slot in the output register
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (w_pub_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/jec_dp.sv]
// ----------------------------------------------------------------------------
// jec_dp - joystick event conditioner datapath
// Configuration registers, button and axis state, publish timer, axis
// dead zone and gain pipeline, and the result register.
// ----------------------------------------------------------------------------
module jec_dp
    import jec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_st,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_func,
    input  logic                  i_init_flag,
    input  logic [7:0]            i_number,
    input  logic signed [15:0]    i_value,
    output logic [31:0]           o_buttons,
    output logic [5:0]            o_button_count,
    output logic [3:0]            o_axis_count,
    output logic                  o_axis_valid,
    output logic [2:0]            o_axis_index,
    output logic signed [15:0]    o_axis_value,
    output logic                  o_last
);

    // configuration
    logic        r_sticky;
    logic [14:0] r_deadzone;
    logic [19:0] r_gain;
    logic [23:0] r_publish_ticks;
    logic [15:0] r_accum_ticks;

    // block state
    logic [MAX_BUTTONS-1:0] r_btn_now, n_btn_now;
    logic [MAX_BUTTONS-1:0] r_btn_prev, n_btn_prev;
    logic [MAX_BUTTONS-1:0] r_btn_tog, n_btn_tog;
    logic [MAX_BUTTONS-1:0] r_pub_btn, n_pub_btn;
    logic [BTN_CNT_W-1:0]   r_btn_seen, n_btn_seen;
    logic [AX_CNT_W-1:0]    r_ax_seen, n_ax_seen;
    logic signed [15:0]     r_store [MAX_AXES];
    logic                   r_win, n_win;
    logic [23:0]            r_ticks, n_ticks;

    // axis pipeline
    logic [AX_IDX_W-1:0]    r_ax_num;
    logic signed [16:0]     r_nd;
    logic signed [37:0]     r_p;

    t_func                  w_func;
    logic                   w_btn_ok, w_ax_ok;
    logic [BTN_IDX_W-1:0]   w_btn_idx;
    logic [AX_IDX_W-1:0]    w_ax_idx;
    logic [BTN_CNT_W-1:0]   w_btn_cnt;
    logic [AX_CNT_W-1:0]    w_ax_cnt;
    logic [MAX_BUTTONS:0]   w_mask_full;
    logic [MAX_BUTTONS-1:0] w_rise;
    logic signed [16:0]     w_v, w_dz, w_d;
    logic [37:0]            w_mag;
    logic [21:0]            w_r;
    logic signed [15:0]     w_res;

    assign w_func    = t_func'(i_func);
    assign w_btn_ok  = i_number < 8'(MAX_BUTTONS);
    assign w_ax_ok   = i_number < 8'(MAX_AXES);
    assign w_btn_idx = i_number[BTN_IDX_W-1:0];
    assign w_ax_idx  = i_number[AX_IDX_W-1:0];
    assign w_btn_cnt = BTN_CNT_W'(w_btn_idx) + 1'b1;
    assign w_ax_cnt  = AX_CNT_W'(w_ax_idx) + 1'b1;

    always_comb begin
        o_st.item_axis = (w_func == FUNC_AXIS) && w_ax_ok;
        o_st.item_pub  = ((w_func == FUNC_BUTTON) && w_btn_ok && i_init_flag)
                      || ((w_func == FUNC_TICK) && (r_ticks <= 24'd1))
                      || ((w_func == FUNC_UNKNOWN) && !r_win);
        // with no axis seen a publish is a single result at index zero
        o_st.last_k    = (r_ax_seen == '0) ? '0 : AX_IDX_W'(r_ax_seen - 1'b1);
    end

    // state updates of an accepted event, with publish effects on top
    always_comb begin
        n_btn_now  = r_btn_now;
        n_btn_prev = r_btn_prev;
        n_btn_tog  = r_btn_tog;
        n_pub_btn  = r_pub_btn;
        n_btn_seen = r_btn_seen;
        n_ax_seen  = r_ax_seen;
        n_win      = r_win;
        n_ticks    = r_ticks;
        if (i_cmd.accept) begin
            case (w_func)
                FUNC_BUTTON: begin
                    if (w_btn_ok) begin
                        if (w_btn_cnt > r_btn_seen) begin
                            n_btn_seen = w_btn_cnt;
                        end
                        n_btn_now[w_btn_idx] = (i_value != '0);
                        if (!i_init_flag && !r_win) begin
                            n_win   = 1'b1;
                            n_ticks = 24'(r_accum_ticks);
                        end
                    end
                end
                FUNC_AXIS: begin
                    if (w_ax_ok) begin
                        if (w_ax_cnt > r_ax_seen) begin
                            n_ax_seen = w_ax_cnt;
                        end
                        if (!r_win) begin
                            n_win   = 1'b1;
                            n_ticks = 24'(r_accum_ticks);
                        end
                    end
                end
                FUNC_TICK: begin
                    if (r_ticks > 24'd1) begin
                        n_ticks = r_ticks - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        w_mask_full = ({{MAX_BUTTONS{1'b0}}, 1'b1} << n_btn_seen) - 1'b1;
        w_rise      = n_btn_now & ~r_btn_prev & w_mask_full[MAX_BUTTONS-1:0];
        if (i_cmd.pub_start) begin
            n_win   = 1'b0;
            n_ticks = r_publish_ticks;
            if (r_sticky) begin
                n_btn_tog  = r_btn_tog ^ w_rise;
                n_btn_prev = n_btn_now;
                n_pub_btn  = r_btn_tog ^ w_rise;
            end else begin
                n_pub_btn  = n_btn_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky        <= 1'b0;
            r_deadzone      <= DEADZONE_RST;
            r_gain          <= AXIS_GAIN_RST;
            r_publish_ticks <= PUBLISH_TICKS_RST;
            r_accum_ticks   <= ACCUM_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_STICKY:   r_sticky        <= i_cfg_data[0];
                REG_DEADZONE: r_deadzone      <= i_cfg_data[14:0];
                REG_GAIN:     r_gain          <= i_cfg_data[19:0];
                REG_PUBLISH:  r_publish_ticks <= i_cfg_data[23:0];
                REG_ACCUM:    r_accum_ticks   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_now  <= '0;
            r_btn_prev <= '0;
            r_btn_tog  <= '0;
            r_btn_seen <= '0;
            r_ax_seen  <= '0;
            r_win      <= 1'b0;
            r_ticks    <= PUBLISH_TICKS_RST;
            for (int i = 0; i < MAX_AXES; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_btn_now  <= n_btn_now;
            r_btn_prev <= n_btn_prev;
            r_btn_tog  <= n_btn_tog;
            r_btn_seen <= n_btn_seen;
            r_ax_seen  <= n_ax_seen;
            r_win      <= n_win;
            r_ticks    <= n_ticks;
            if (i_cmd.store_wr) begin
                r_store[r_ax_num] <= w_res;
            end
        end
    end

    // dead zone removal, negated, captured at event transfer
    always_comb begin
        w_v  = 17'(i_value);
        w_dz = $signed({2'b00, r_deadzone});
        if (w_v < -w_dz) begin
            w_d = w_v + w_dz;
        end else if (w_v > w_dz) begin
            w_d = w_v - w_dz;
        end else begin
            w_d = '0;
        end
    end

    // round half away from zero at 2^-16, then saturate
    always_comb begin
        w_mag = r_p[37] ? 38'(-r_p) : 38'(r_p);
        w_r   = 22'((w_mag + 38'd32768) >> 16);
        if (r_p[37]) begin
            w_res = (w_r > 22'd32768) ? -16'sd32768 : 16'(-w_r);
        end else begin
            w_res = (w_r > 22'd32767) ? 16'sd32767 : 16'(w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ax_num <= w_ax_idx;
            r_nd     <= -w_d;
        end
        if (i_cmd.mul) begin
            r_p <= 38'(r_nd * $signed({1'b0, r_gain}));
        end
        r_pub_btn <= n_pub_btn;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_buttons      <= 32'(r_pub_btn);
            o_button_count <= r_btn_seen;
            o_axis_count   <= r_ax_seen;
            o_last         <= (i_cmd.k == o_st.last_k);
            if (r_ax_seen == '0) begin
                o_axis_valid <= 1'b0;
                o_axis_index <= '0;
                o_axis_value <= '0;
            end else begin
                o_axis_valid <= 1'b1;
                o_axis_index <= 3'(i_cmd.k);
                o_axis_value <= r_store[i_cmd.k];
            end
        end
    end

endmodule

[rtl/joystick_event_conditioner_core.sv]
// ----------------------------------------------------------------------------
// joystick_event_conditioner_core - joystick event conditioner top level
// Controller and datapath joined by command and status groups.
// ----------------------------------------------------------------------------
// Usage:
//  i_evt carries button, axis, timer tick and unknown events. An event
//  transfer is taken in the idle state; an axis event then has its dead
//  zone removed at the transfer, is multiplied by the gain, and is then
//  rounded, saturated and stored before the next event is taken. Button,
//  tick and unknown events that do not publish leave the controller idle.
//  A publishing event streams one result per axis seen (or one result if
//  no axis is seen yet) on o_res, one per cycle while the receiver takes
//  them, through a single result register; the register loads in the
//  publish state whenever it is free, and the event channel stays closed
//  while the results are loaded.
//  Events are taken again once the last result is loaded, even while it
//  still waits in the result register. A stalled receiver holds the result
//  and halts the stream.
//  i_cfg writes registers 0..4 and is always ready.
//  Reset clears the button and axis state and loads the default register
//  values; the publish timer restarts from the default interval.
// ----------------------------------------------------------------------------
module joystick_event_conditioner_core
    import jec_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    jec_evt_if.sink   i_evt,
    jec_res_if.source o_res,
    jec_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_st;

    assign i_cfg.ready = 1'b1;

    jec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .i_out_ready (o_res.ready),
        .i_st        (w_st),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    jec_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_func         (i_evt.func),
        .i_init_flag    (i_evt.init_flag),
        .i_number       (i_evt.number),
        .i_value        (i_evt.value),
        .o_buttons      (o_res.buttons),
        .o_button_count (o_res.button_count),
        .o_axis_count   (o_res.axis_count),
        .o_axis_valid   (o_res.axis_valid),
        .o_axis_index   (o_res.axis_index),
        .o_axis_value   (o_res.axis_value),
        .o_last         (o_res.last)
    );

    a_no_accept_while_streaming: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !i_evt.ready)
        else $error("event taken while a publish streams");

    a_pub_start_on_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pub_start |-> (i_evt.valid && i_evt.ready))
        else $error("publish started without an event transfer");

    a_last_reopens_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out && (w_cmd.k == w_st.last_k)) |=> i_evt.ready)
        else $error("event channel not reopened after last result");

    a_load_sets_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_res.valid)
        else $error("loaded result not presented");

    a_store_write_returns_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store_wr |=> i_evt.ready)
        else $error("axis write did not return to idle");

endmodule

[test/jec_frame_checker.sv]
// ----------------------------------------------------------------------------
// jec_frame_checker - joystick event conditioner result checker
// Watches the event, configuration and result channels. Keeps its own copy
// of the button, axis and timer state, works out the frames every accepted
// event publishes and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module jec_frame_checker
    import jec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    jec_evt_if   evt,
    jec_res_if   res,
    jec_cfg_if   cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [31:0]        buttons;
        logic [5:0]         button_count;
        logic [3:0]         axis_count;
        logic               axis_valid;
        logic [2:0]         axis_index;
        logic signed [15:0] axis_value;
        logic               last;
    } t_frame;

    t_frame frames_due[$];
    int     mismatches = 0;

    // register copies
    logic        sticky;
    logic [14:0] deadzone;
    logic [19:0] gain;
    logic [23:0] pub_ticks;
    logic [15:0] accum_ticks;

    // conditioner state
    logic [31:0]        btn_now;
    logic [31:0]        btn_prev;
    logic [31:0]        btn_toggled;
    logic [5:0]         btn_seen;
    logic [3:0]         axes_seen;
    logic signed [15:0] axis_store [MAX_AXES];
    logic               window_open;
    logic [23:0]        ticks_left;

    function automatic void publish_frames();
        logic [31:0] shown;
        logic [31:0] seen_mask;
        t_frame      f;
        int          k;
        if (sticky) begin
            seen_mask   = 32'((64'd1 << btn_seen) - 64'd1);
            btn_toggled = btn_toggled ^ (btn_now & ~btn_prev & seen_mask);
            btn_prev    = btn_now;
            shown       = btn_toggled;
        end else begin
            shown = btn_now;
        end
        window_open    = 1'b0;
        ticks_left     = pub_ticks;
        f.buttons      = shown;
        f.button_count = btn_seen;
        f.axis_count   = axes_seen;
        if (axes_seen == 0) begin
            f.axis_valid = 1'b0;
            f.axis_index = '0;
            f.axis_value = '0;
            f.last       = 1'b1;
            frames_due.push_back(f);
        end else begin
            for (k = 0; k < axes_seen; k++) begin
                f.axis_valid = 1'b1;
                f.axis_index = 3'(k);
                f.axis_value = axis_store[k];
                f.last       = (k == axes_seen - 1);
                frames_due.push_back(f);
            end
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_frame want;
        t_frame got;
        longint raw, dz, d, p, mag, r;
        int     i;
        if (!i_rst_n) begin
            sticky      = 1'b0;
            deadzone    = DEADZONE_RST;
            gain        = AXIS_GAIN_RST;
            pub_ticks   = PUBLISH_TICKS_RST;
            accum_ticks = ACCUM_TICKS_RST;
            btn_now     = '0;
            btn_prev    = '0;
            btn_toggled = '0;
            btn_seen    = '0;
            axes_seen   = '0;
            for (i = 0; i < MAX_AXES; i++)
                axis_store[i] = '0;
            window_open = 1'b0;
            ticks_left  = PUBLISH_TICKS_RST;
            frames_due.delete();
        end else begin
            if (res.valid && res.ready) begin
                got.buttons      = res.buttons;
                got.button_count = res.button_count;
                got.axis_count   = res.axis_count;
                got.axis_valid   = res.axis_valid;
                got.axis_index   = res.axis_index;
                got.axis_value   = res.axis_value;
                got.last         = res.last;
                if (frames_due.size() == 0) begin
                    $display("%0t: result with none expected, got buttons 'h%0h axis %0d value %0d last %b",
                             $time, got.buttons, got.axis_index, got.axis_value, got.last);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("buttons", want.buttons, got.buttons);
                    check_field("button_count", want.button_count, got.button_count);
                    check_field("axis_count", want.axis_count, got.axis_count);
                    check_field("axis_valid", want.axis_valid, got.axis_valid);
                    check_field("axis_index", want.axis_index, got.axis_index);
                    check_field("axis_value", $unsigned(want.axis_value), $unsigned(got.axis_value));
                    check_field("last", want.last, got.last);
                end
            end

            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_STICKY:   sticky      = cfg.data[0];
                    REG_DEADZONE: deadzone    = cfg.data[14:0];
                    REG_GAIN:     gain        = cfg.data[19:0];
                    REG_PUBLISH:  pub_ticks   = cfg.data;
                    REG_ACCUM:    accum_ticks = cfg.data[15:0];
                    default: ;
                endcase
            end

            if (evt.valid && evt.ready) begin
                case (evt.func)
                    FUNC_BUTTON: begin
                        if (evt.number < MAX_BUTTONS) begin
                            if (evt.number + 1 > btn_seen)
                                btn_seen = 6'(evt.number + 1);
                            btn_now[evt.number[4:0]] = (evt.value != 0);
                            if (evt.init_flag) begin
                                publish_frames();
                            end else if (!window_open) begin
                                window_open = 1'b1;
                                ticks_left  = 24'(accum_ticks);
                            end
                        end
                    end
                    FUNC_AXIS: begin
                        if (evt.number < MAX_AXES) begin
                            if (evt.number + 1 > axes_seen)
                                axes_seen = 4'(evt.number + 1);
                            // strip the dead zone, negate, scale, round at bit 16
                            raw = longint'($signed(evt.value));
                            dz  = longint'(deadzone);
                            if (raw < -dz)
                                d = raw + dz;
                            else if (raw > dz)
                                d = raw - dz;
                            else
                                d = 0;
                            p   = -d * longint'(gain);
                            mag = (p < 0) ? -p : p;
                            r   = (mag + 32768) >>> 16;
                            if (r > 40000)
                                r = 40000;
                            if (p < 0)
                                r = -r;
                            if (r > 32767)
                                r = 32767;
                            else if (r < -32768)
                                r = -32768;
                            axis_store[evt.number[2:0]] = 16'(r);
                            if (!window_open) begin
                                window_open = 1'b1;
                                ticks_left  = 24'(accum_ticks);
                            end
                        end
                    end
                    FUNC_TICK: begin
                        if (ticks_left <= 1)
                            publish_frames();
                        else
                            ticks_left = ticks_left - 1;
                    end
                    default: begin
                        // unknown event: publish only outside a window
                        if (!window_open)
                            publish_frames();
                    end
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= frames_due.size();
    end

endmodule

[test/tb_joystick_event_conditioner_core.sv]
// ----------------------------------------------------------------------------
// tb_joystick_event_conditioner_core - joystick event conditioner testbench
// Drives button, axis, tick and unknown events with random gaps and result
// stalls, reprograms the registers between phases once all frames are out,
// and leaves prediction and comparison to the frame checker.
// ----------------------------------------------------------------------------
module tb_joystick_event_conditioner_core;
    import jec_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 37;

    logic        i_clk;
    logic        i_rst_n;
    bit          evt_gaps_on;
    bit          res_stalls_on;
    logic [14:0] cur_deadzone;
    int          fail_count;
    int          pending;

    jec_evt_if evt ();
    jec_res_if res ();
    jec_cfg_if cfg ();

    joystick_event_conditioner_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    jec_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .evt          (evt),
        .res          (res),
        .cfg          (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hold ready low for a drawn number of cycles with a result on offer
    initial begin : ready_driver
        int stall;
        stall = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready)
                stall = res_stalls_on ? $urandom_range(0, 7) : 0;
            else if (res.valid && stall > 0)
                stall--;
            res.ready <= (stall == 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (evt.valid && evt.ready) || (res.valid && res.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_event(input t_func f, input bit init, input logic [7:0] num,
                              input logic [15:0] val);
        int gap;
        gap = evt_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            evt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt.valid     <= 1'b1;
        evt.func      <= f;
        evt.init_flag <= init;
        evt.number    <= num;
        evt.value     <= val;
        @(posedge i_clk);
        while (!evt.ready) @(posedge i_clk);
    endtask

    task automatic send_random_event();
        int          pick;
        t_func       f;
        logic [7:0]  num;
        logic [15:0] val;
        bit          init;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            f = FUNC_BUTTON;
        else if (pick < 65)
            f = FUNC_AXIS;
        else if (pick < 92)
            f = FUNC_TICK;
        else
            f = FUNC_UNKNOWN;
        if ($urandom_range(0, 9) == 0)
            num = 8'($urandom_range(0, 255));
        else if (f == FUNC_AXIS)
            num = 8'($urandom_range(0, MAX_AXES - 1));
        else
            num = 8'($urandom_range(0, MAX_BUTTONS - 1));
        val = 16'($urandom);
        if (f == FUNC_BUTTON && $urandom_range(0, 1) == 0)
            val = '0;
        // land near the dead zone edges now and then
        if (f == FUNC_AXIS && $urandom_range(0, 3) == 0) begin
            val = 16'(cur_deadzone + $urandom_range(0, 4) - 2);
            if ($urandom_range(0, 1) == 0)
                val = -val;
        end
        init = ($urandom_range(0, 6) == 0);
        send_event(f, init, num, val);
    endtask

    // drop valid, wait for every frame, then let a trailing axis update settle
    task automatic drain();
        evt.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
    endtask

    task automatic set_registers(input bit sticky, input logic [14:0] dz,
                                 input logic [19:0] gain, input logic [23:0] pub,
                                 input logic [15:0] acc);
        write_reg(REG_STICKY, 24'(sticky));
        write_reg(REG_DEADZONE, 24'(dz));
        write_reg(REG_GAIN, 24'(gain));
        write_reg(REG_PUBLISH, pub);
        write_reg(REG_ACCUM, 24'(acc));
        cfg.valid <= 1'b0;
        cur_deadzone = dz;
    endtask

    initial begin : stimulus
        int          ph;
        int          n;
        logic [14:0] dz;
        longint      span;
        evt.valid     <= 1'b0;
        evt.func      <= FUNC_BUTTON;
        evt.init_flag <= 1'b0;
        evt.number    <= '0;
        evt.value     <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_STICKY;
        cfg.data      <= '0;
        i_rst_n       <= 1'b0;
        evt_gaps_on   = 1'b1;
        res_stalls_on = 1'b1;
        cur_deadzone  = DEADZONE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: raw buttons, one-tick window
        send_event(FUNC_UNKNOWN, 1'b0, 8'd0, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 8'hFF, 16'hFFFF);
        send_event(FUNC_BUTTON, 1'b0, 8'd31, 16'h0001);
        send_event(FUNC_UNKNOWN, 1'b1, 8'd0, 16'h0000);
        send_event(FUNC_AXIS, 1'b0, 8'd7, 16'h7FFF);
        send_event(FUNC_AXIS, 1'b0, 8'd0, 16'h8000);
        send_event(FUNC_AXIS, 1'b0, 8'd1, 16'd1638);
        send_event(FUNC_AXIS, 1'b0, 8'd2, 16'd1639);
        send_event(FUNC_AXIS, 1'b1, 8'd3, -16'sd1639);
        send_event(FUNC_AXIS, 1'b0, 8'd8, 16'h1234);
        send_event(FUNC_BUTTON, 1'b0, 8'd32, 16'h0001);
        send_event(FUNC_BUTTON, 1'b1, 8'hFF, 16'h0001);
        send_event(FUNC_AXIS, 1'b0, 8'hFF, 16'h0001);
        send_event(FUNC_TICK, 1'b0, 8'd0, 16'h0000);
        send_event(FUNC_BUTTON, 1'b1, 8'd0, 16'h8000);
        drain();

        // sticky buttons, no dead zone, full gain, zero intervals
        set_registers(1'b1, 15'd0, 20'hFFFFF, 24'd0, 16'd0);
        send_event(FUNC_BUTTON, 1'b0, 8'd3, 16'h0001);
        send_event(FUNC_AXIS, 1'b0, 8'd0, 16'h7FFF);
        send_event(FUNC_AXIS, 1'b0, 8'd1, 16'h8000);
        send_event(FUNC_TICK, 1'b0, 8'd0, 16'h0000);
        send_event(FUNC_BUTTON, 1'b0, 8'd3, 16'h0000);
        send_event(FUNC_TICK, 1'b0, 8'd0, 16'h0000);
        send_event(FUNC_BUTTON, 1'b0, 8'd3, 16'hFFFF);
        send_event(FUNC_TICK, 1'b0, 8'd0, 16'h0000);
        send_event(FUNC_UNKNOWN, 1'b0, 8'd0, 16'h0000);
        send_event(FUNC_BUTTON, 1'b1, 8'd31, 16'h4000);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_registers(1'b0, 15'd29490, 20'd0, 24'd3, 16'hFFFF);
                1: set_registers(1'b1, 15'h7FFF, 20'hFFFFF, 24'hFFFFFF, 16'd2);
                default: begin
                    dz   = 15'($urandom_range(0, 29490));
                    span = 32767 - longint'(dz);
                    if ($urandom_range(0, 3) == 0)
                        set_registers(1'($urandom), dz, 20'($urandom),
                                      24'($urandom_range(0, 6)), 16'($urandom_range(0, 4)));
                    else
                        set_registers(1'($urandom), dz, 20'(((64'd1 << 31) + span / 2) / span),
                                      24'($urandom_range(0, 6)), 16'($urandom_range(0, 4)));
                end
            endcase
            evt_gaps_on   = ($urandom_range(0, 3) != 0);
            res_stalls_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_event();
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/jec_pkg.sv
rtl/jec_ifs.sv
rtl/jec_ctrl.sv
rtl/jec_dp.sv
rtl/joystick_event_conditioner_core.sv
test/jec_frame_checker.sv
test/tb_joystick_event_conditioner_core.sv
